FILE: hdl/tpq_pkg.sv
// Shared types and constants for the timer priority queue.
`default_nettype none
package tpq_pkg;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NUM_SLOTS_DEF = 16;
	localparam int TIME_BITS_DEF = 48;
	localparam int ID_W = 4;
	localparam int MIN_ARM_W = 20;
	localparam logic [MIN_ARM_W-1:0] MIN_ARM_RESET = 20'd100;
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_CANCEL = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;
	// unused action code: answered with a plain status word
	localparam logic [1:0] ACT_RSVD = 2'd3;
	// result word: fired_valid, fired_id, arm_valid, arm_delay, ec, rej, qe
	localparam int RES_W = 1 + ID_W + 1 + 48 + 1 + 1 + 1;
	localparam int RES_BYTES_W = ((RES_W + 7) / 8) * 8;
	localparam int IN_W = 2 + ID_W + 48 * 3;
	localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
endpackage
`default_nettype wire

FILE: hdl/timer_priority_queue_top.sv
// Top level of the timer priority queue: sequencer, entry store and output word.
// Insert: a scan over the queued entries, one update in S_INS, then the word is loaded in S_OUT;
// cancel and unknown actions go straight to S_OUT, which loads their word when the output is free.
// Tick: repeated scan and pop of the earliest due entry, a last check, a requeue pass over the popped
// entries, a final scan, then the fired words (held while m_axis_tready is low).
// One item at a time (s_axis_tready high only in idle); arst_n low empties queue, min arm = 100.
`default_nettype none
module timer_priority_queue_top #(
	parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// action[1:0], timer_id[5:2], expire_time, interval_us, now_us (48 each), zero pad
	input wire logic [tpq_pkg::IN_BYTES_W-1:0] s_axis_tdata,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [tpq_pkg::MIN_ARM_W-1:0] cfg_data,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// fired_valid, fired_id[4], arm_valid, arm_delay[48], earliest_changed,
	// insert_rejected, queue_empty, zero pad
	output logic [tpq_pkg::RES_BYTES_W-1:0] m_axis_tdata,
	output logic m_axis_tlast
);
	localparam int NUM_SLOTS = tpq_pkg::NUM_SLOTS_DEF;
	localparam int TB = tpq_pkg::TIME_BITS_DEF;
	localparam int ID_WL = tpq_pkg::ID_W;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = $clog2(NUM_SLOTS);
	localparam logic [TB-1:0] TMAX = {TB{1'b1}};

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_INS, S_POPCHK, S_POPRD, S_RESCAN, S_REQ,
		S_FINSCAN, S_FINAL, S_FIRE, S_OUT
	} state_t;

	state_t state_q;
	logic [TB-1:0] etime_q [QUEUE_DEPTH];
	logic [ID_WL-1:0] eslot_q [QUEUE_DEPTH];
	logic [TB-1:0] sint_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] canc_q;
	logic [CW-1:0] cnt_q;
	logic [tpq_pkg::MIN_ARM_W-1:0] minarm_q;

	logic [ID_WL-1:0] id_q;
	logic [TB-1:0] exp_q, int_q, now_q;
	// scan unit: walks the entries one per cycle keeping the best
	logic [CW-1:0] idx_q;
	logic [QW-1:0] best_q;
	logic [TB-1:0] btime_q;
	logic [ID_WL-1:0] bslot_q;
	// popped list, walked again for requeue and for the fired words
	logic [ID_WL-1:0] pop_q [QUEUE_DEPTH];
	logic [CW-1:0] npop_q, ri_q, nfired_q, kf_q;
	logic ec_q, rej_q, av_q;
	logic [TB-1:0] ad_q;
	logic [TB:0] sum;
	logic [TB-1:0] req_t;
	logic [ID_WL-1:0] cur_s;

	logic [TB-1:0] it;
	logic [ID_WL-1:0] is;
	logic better;
	logic [QW-1:0] tail;
	logic [TB-1:0] arm_e, arm_d;
	logic slot_ok, cur_live;
	logic out_free, emit_fire, emit_one, load_out, fire_last, out_last;
	logic [tpq_pkg::RES_BYTES_W-1:0] out_word;

	function automatic logic [TB-1:0] armd(input logic [TB-1:0] e, input logic [TB-1:0] n,
			input logic [tpq_pkg::MIN_ARM_W-1:0] m);
		logic [TB-1:0] d;
		d = (e > n) ? e - n : '0;
		if (d < TB'(m)) d = TB'(m);
		return d;
	endfunction

	assign it = etime_q[idx_q[QW-1:0]];
	assign is = eslot_q[idx_q[QW-1:0]];
	assign better = (it < btime_q) || (it == btime_q && is < bslot_q);
	assign tail = QW'(cnt_q - CW'(1));
	assign cur_s = pop_q[ri_q[QW-1:0]];
	assign sum = {1'b0, now_q} + {1'b0, sint_q[cur_s[SW-1:0]]};
	assign req_t = sum[TB] ? TMAX : sum[TB-1:0];
	assign slot_ok = (32'(id_q) < NUM_SLOTS);
	assign cur_live = (32'(cur_s) < NUM_SLOTS) && !canc_q[cur_s[SW-1:0]];
	// one arm-delay unit, shared by insert and the end of a tick
	assign arm_e = (state_q == S_INS) ? exp_q : btime_q;
	assign arm_d = armd(arm_e, now_q, minarm_q);

	// config write wins over a new word in idle
	assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);

	// output register: loads when empty or being taken
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign fire_last = (kf_q + CW'(1) == nfired_q);
	assign emit_fire = (state_q == S_FIRE) && out_free && (ri_q < npop_q) && cur_live;
	assign emit_one = (state_q == S_OUT) && out_free;
	assign load_out = emit_fire || emit_one;
	assign out_last = emit_one || fire_last;

	always_comb begin
		out_word = '0;
		out_word[0] = emit_fire;
		out_word[4:1] = emit_fire ? cur_s : '0;
		// arm fields ride only on the last word of an item
		out_word[5] = out_last ? av_q : 1'b0;
		out_word[6 +: 48] = out_last ? 48'(ad_q) : '0;
		out_word[54] = emit_one && ec_q;
		out_word[55] = emit_one && rej_q;
		out_word[56] = (cnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			canc_q <= '0;
			cnt_q <= '0;
			minarm_q <= tpq_pkg::MIN_ARM_RESET;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			m_axis_tlast <= 1'b0;
		end else begin
			if (load_out) begin
				m_axis_tvalid <= 1'b1;
				m_axis_tdata <= out_word;
				m_axis_tlast <= out_last;
			end else if (m_axis_tready) m_axis_tvalid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) minarm_q <= cfg_data;
					else if (s_axis_tvalid) begin
						id_q <= s_axis_tdata[5:2];
						exp_q <= s_axis_tdata[6 +: TB];
						int_q <= s_axis_tdata[6 + TB +: TB];
						now_q <= s_axis_tdata[6 + 2 * TB +: TB];
						idx_q <= CW'(1);
						best_q <= '0;
						btime_q <= etime_q[0];
						bslot_q <= eslot_q[0];
						ec_q <= 1'b0; rej_q <= 1'b0; av_q <= 1'b0; ad_q <= '0;
						npop_q <= '0; nfired_q <= '0; kf_q <= '0;
						unique case (s_axis_tdata[1:0])
							tpq_pkg::ACT_INSERT: state_q <= S_SCAN;
							tpq_pkg::ACT_CANCEL: begin
								if (32'(s_axis_tdata[5:2]) < NUM_SLOTS)
									canc_q[s_axis_tdata[2 +: SW]] <= 1'b1;
								state_q <= S_OUT;
							end
							tpq_pkg::ACT_TICK: state_q <= S_POPCHK;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_SCAN, S_POPCHK, S_FINSCAN: begin
					if (idx_q < cnt_q) begin
						if (better) begin
							best_q <= idx_q[QW-1:0];
							btime_q <= it;
							bslot_q <= is;
						end
						idx_q <= idx_q + CW'(1);
					end else begin
						if (state_q == S_SCAN) state_q <= S_INS;
						else if (state_q == S_FINSCAN) state_q <= S_FINAL;
						else state_q <= S_POPRD;
					end
				end
				S_INS: begin
					if (!slot_ok || cnt_q >= CW'(QUEUE_DEPTH)) rej_q <= 1'b1;
					else begin
						if (cnt_q == '0 || exp_q < btime_q) begin
							ec_q <= 1'b1; av_q <= 1'b1;
							ad_q <= arm_d;
						end
						sint_q[id_q[SW-1:0]] <= int_q;
						canc_q[id_q[SW-1:0]] <= 1'b0;
						etime_q[QW'(cnt_q)] <= exp_q;
						eslot_q[QW'(cnt_q)] <= id_q;
						cnt_q <= cnt_q + CW'(1);
					end
					state_q <= S_OUT;
				end
				S_POPRD: begin
					// pop the earliest entry if it is before now_q, tail entry fills its place
					if (cnt_q != '0 && btime_q < now_q) begin
						pop_q[npop_q[QW-1:0]] <= bslot_q;
						npop_q <= npop_q + CW'(1);
						etime_q[best_q] <= etime_q[tail];
						eslot_q[best_q] <= eslot_q[tail];
						cnt_q <= cnt_q - CW'(1);
						state_q <= S_RESCAN;
					end else begin
						ri_q <= '0;
						state_q <= S_REQ;
					end
				end
				S_RESCAN: begin
					// restart scan for the next pop
					idx_q <= CW'(1);
					best_q <= '0;
					btime_q <= etime_q[0];
					bslot_q <= eslot_q[0];
					state_q <= S_POPCHK;
				end
				S_REQ: begin
					if (ri_q < npop_q) begin
						if (cur_live) begin
							nfired_q <= nfired_q + CW'(1);
							if (sint_q[cur_s[SW-1:0]] != '0) begin
								etime_q[QW'(cnt_q)] <= req_t;
								eslot_q[QW'(cnt_q)] <= cur_s;
								cnt_q <= cnt_q + CW'(1);
							end
						end
						ri_q <= ri_q + CW'(1);
					end else begin
						idx_q <= CW'(1);
						best_q <= '0;
						btime_q <= etime_q[0];
						bslot_q <= eslot_q[0];
						state_q <= S_FINSCAN;
					end
				end
				S_FINAL: begin
					if (cnt_q != '0) begin
						av_q <= 1'b1;
						ad_q <= arm_d;
					end
					ri_q <= '0;
					state_q <= S_FIRE;
				end
				S_FIRE: begin
					// fired words in pop order, cancelled slots skipped
					if (ri_q < npop_q) begin
						if (!cur_live) ri_q <= ri_q + CW'(1);
						else if (out_free) begin
							ri_q <= ri_q + CW'(1);
							kf_q <= kf_q + CW'(1);
							if (fire_last) state_q <= S_IDLE;
						end
					end else state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tlast)) else $error("output word changed while stalled");
`endif
endmodule
`default_nettype wire
